/* hdl/fcm_pkg.sv */
// ----------------------------------------------------------------------------
// fcm_pkg: shared definitions for the allocation table chain manager
// Sizes, command and status codes, and the table write bundle.
// ----------------------------------------------------------------------------
package fcm_pkg;

  localparam int BLOCK_COUNT = 1024;
  localparam int BLOCK_W     = $clog2(BLOCK_COUNT);
  localparam int LINK_W      = BLOCK_W + 1;
  localparam int STEP_W      = $clog2(BLOCK_COUNT + 1);
  localparam int OFFSET_W    = 24;
  localparam int BSZ_W       = 17;
  localparam int CMD_W       = 3;
  localparam int STATUS_W    = 2;

  localparam logic [LINK_W-1:0] END_LINK          = '1;
  localparam logic [BSZ_W-1:0]  BLOCK_BYTES_RESET = 17'd1024;

  localparam logic [CMD_W-1:0] CMD_CREATE   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_EXTEND   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_TRUNCATE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TAIL     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SEEK     = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_FREE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_HEAD_UNUSED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_CHAIN_END   = 2'd3;

  typedef struct packed {
    logic               used_we;
    logic [BLOCK_W-1:0] used_addr;
    logic               used_data;
    logic               link_we;
    logic [BLOCK_W-1:0] link_addr;
    logic [LINK_W-1:0]  link_data;
  } tbl_wr_t;

endpackage

/* hdl/fcm_tables.sv */
// ----------------------------------------------------------------------------
// fcm_tables: block-used bitmap and next-block link table
// Two single-port-write memories sharing one read address, with registered read data.
// ----------------------------------------------------------------------------
module fcm_tables import fcm_pkg::*; (
  input  logic               clk,
  input  logic [BLOCK_W-1:0] rd_addr,
  input  tbl_wr_t            wr,
  output logic               used_q,
  output logic [LINK_W-1:0]  link_q
);

  logic              used_mem [BLOCK_COUNT];
  logic [LINK_W-1:0] link_mem [BLOCK_COUNT];

  always_ff @(posedge clk) begin
    if (wr.used_we) begin
      used_mem[wr.used_addr] <= wr.used_data;
    end
    used_q <= used_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr.link_we) begin
      link_mem[wr.link_addr] <= wr.link_data;
    end
    link_q <= link_mem[rd_addr];
  end

endmodule

/* hdl/fat_chain_manager.sv */
// ----------------------------------------------------------------------------
// fat_chain_manager: allocation bitmap and block chain sequencer
// Create and extend run a free scan for the lowest free block, which reads
// one bitmap entry a cycle; find-tail, seek and truncate walk the links of
// the chain; an unused head block or a reserved command ends without either.
// One item at a time: busy drops in the cycle that done is high; no stall.
// Reset starts a clearing pass over all 1024 blocks of both tables with busy high.
// ----------------------------------------------------------------------------
module fat_chain_manager import fcm_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [BLOCK_W-1:0]  block,
  input  logic [OFFSET_W-1:0] byte_offset,
  input  logic                cfg_write,
  input  logic [BSZ_W-1:0]    cfg_data,
  output logic                done,
  output logic [STATUS_W-1:0] status,
  output logic [BLOCK_W-1:0]  result_block,
  output logic [OFFSET_W-1:0] offset_left
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_DECIDE = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_ALLOC  = 4'd5;
  localparam logic [3:0] S_LINK   = 4'd6;
  localparam logic [3:0] S_WREQ   = 4'd7;
  localparam logic [3:0] S_WUSE   = 4'd8;
  localparam logic [3:0] S_TEND   = 4'd9;

  localparam logic [BLOCK_W-1:0] LAST_BLOCK = BLOCK_W'(BLOCK_COUNT - 1);

  logic [3:0]          state;
  logic [BLOCK_W-1:0]  clr_idx;
  logic [CMD_W-1:0]    cmd_q;
  logic [BLOCK_W-1:0]  blk_q;
  logic [OFFSET_W-1:0] off_q;
  logic [BLOCK_W-1:0]  cur;
  logic [LINK_W-1:0]   old_link;
  logic [STEP_W-1:0]   steps;
  logic [BLOCK_W-1:0]  scan_idx;
  logic [BLOCK_W-1:0]  chk_idx;
  logic                chk_valid;
  logic [BSZ_W-1:0]    block_bytes;

  logic                used_q;
  logic [LINK_W-1:0]   link_q;
  logic [BLOCK_W-1:0]  rd_addr;
  tbl_wr_t             wr;

  logic                has_next;
  logic                walk_go;
  logic [OFFSET_W-1:0] bsz;
  logic                seek_more;

  fcm_tables u_tables (
    .clk     (clk),
    .rd_addr (rd_addr),
    .wr      (wr),
    .used_q  (used_q),
    .link_q  (link_q)
  );

  assign busy      = (state != S_IDLE);
  assign has_next  = (link_q < LINK_W'(BLOCK_COUNT));
  assign walk_go   = (steps < STEP_W'(BLOCK_COUNT)) && has_next;
  assign bsz       = (block_bytes == '0) ? OFFSET_W'(1) : OFFSET_W'(block_bytes);
  assign seek_more = (off_q > bsz);

  always_comb begin
    case (state)
      S_SCAN:  rd_addr = scan_idx;
      S_WREQ:  rd_addr = cur;
      default: rd_addr = blk_q;
    endcase
  end

  always_comb begin
    wr = '0;
    case (state)
      S_CLEAR: begin
        wr.used_we   = 1'b1;
        wr.used_addr = clr_idx;
        wr.used_data = 1'b0;
        wr.link_we   = 1'b1;
        wr.link_addr = clr_idx;
        wr.link_data = END_LINK;
      end
      S_ALLOC: begin
        wr.used_we   = 1'b1;
        wr.used_addr = cur;
        wr.used_data = 1'b1;
        wr.link_we   = 1'b1;
        wr.link_addr = cur;
        wr.link_data = (cmd_q == CMD_EXTEND) ? old_link : END_LINK;
      end
      S_LINK: begin
        wr.link_we   = 1'b1;
        wr.link_addr = blk_q;
        wr.link_data = {1'b0, cur};
      end
      S_WUSE: begin
        if (cmd_q == CMD_TRUNCATE) begin
          wr.link_addr = cur;
          wr.link_data = END_LINK;
          if (walk_go) begin
            wr.link_we   = (cur != blk_q);
            wr.used_we   = 1'b1;
            wr.used_addr = link_q[BLOCK_W-1:0];
            wr.used_data = 1'b0;
          end else begin
            wr.link_we   = 1'b1;
          end
        end
      end
      S_TEND: begin
        wr.link_we   = 1'b1;
        wr.link_addr = blk_q;
        wr.link_data = END_LINK;
      end
      default: begin
        wr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes <= BLOCK_BYTES_RESET;
    end else if (cfg_write) begin
      block_bytes <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      done      <= 1'b0;
      chk_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_BLOCK) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (start) begin
            cmd_q <= cmd;
            blk_q <= block;
            off_q <= byte_offset;
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          scan_idx  <= '0;
          chk_valid <= 1'b0;
          cur       <= blk_q;
          steps     <= '0;
          if (cmd_q == CMD_CREATE) begin
            state <= S_SCAN;
          end else if (cmd_q > CMD_SEEK) begin
            done         <= 1'b1;
            status       <= ST_OK;
            result_block <= '0;
            offset_left  <= '0;
            state        <= S_IDLE;
          end else if (!used_q) begin
            done         <= 1'b1;
            status       <= ST_HEAD_UNUSED;
            result_block <= '0;
            offset_left  <= '0;
            state        <= S_IDLE;
          end else if (cmd_q == CMD_EXTEND) begin
            old_link <= link_q;
            state    <= S_SCAN;
          end else begin
            state <= S_WUSE;
          end
        end
        S_SCAN: begin
          if (chk_valid && !used_q) begin
            cur   <= chk_idx;
            state <= S_ALLOC;
          end else if (chk_valid && (chk_idx == LAST_BLOCK)) begin
            done         <= 1'b1;
            status       <= ST_NO_FREE;
            result_block <= '0;
            offset_left  <= '0;
            state        <= S_IDLE;
          end else begin
            chk_idx   <= scan_idx;
            chk_valid <= 1'b1;
            scan_idx  <= scan_idx + 1'b1;
          end
        end
        S_ALLOC: begin
          if (cmd_q == CMD_EXTEND) begin
            state <= S_LINK;
          end else begin
            done         <= 1'b1;
            status       <= ST_OK;
            result_block <= cur;
            offset_left  <= '0;
            state        <= S_IDLE;
          end
        end
        S_LINK: begin
          done         <= 1'b1;
          status       <= ST_OK;
          result_block <= cur;
          offset_left  <= '0;
          state        <= S_IDLE;
        end
        S_WREQ: begin
          state <= S_WUSE;
        end
        S_WUSE: begin
          if (cmd_q == CMD_SEEK) begin
            if (seek_more && walk_go) begin
              cur   <= link_q[BLOCK_W-1:0];
              off_q <= off_q - bsz;
              steps <= steps + 1'b1;
              state <= S_WREQ;
            end else begin
              done         <= 1'b1;
              status       <= seek_more ? ST_CHAIN_END : ST_OK;
              result_block <= cur;
              offset_left  <= off_q;
              state        <= S_IDLE;
            end
          end else if (walk_go) begin
            cur   <= link_q[BLOCK_W-1:0];
            steps <= steps + 1'b1;
            state <= S_WREQ;
          end else if (cmd_q == CMD_TRUNCATE) begin
            state <= S_TEND;
          end else begin
            done         <= 1'b1;
            status       <= ST_OK;
            result_block <= cur;
            offset_left  <= '0;
            state        <= S_IDLE;
          end
        end
        S_TEND: begin
          done         <= 1'b1;
          status       <= ST_OK;
          result_block <= blk_q;
          offset_left  <= '0;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result strobe without an item in progress");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_fail_no_block: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_NO_FREE || status == ST_HEAD_UNUSED))
      |-> (result_block == '0 && offset_left == '0))
    else $error("failed command reported a block or an offset");

  a_chain_end_seek: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_CHAIN_END) |-> (cmd_q == CMD_SEEK && offset_left > bsz))
    else $error("chain end reported outside a seek walk");

endmodule

/* dv/fat_chain_manager_tb.sv */
// ----------------------------------------------------------------------------
// fat_chain_manager_tb: self-checking testbench for the chain manager
// Drives create, extend, truncate, find-tail, seek and reserved commands,
// keeps its own copy of the used bitmap, link table and block size, and
// checks every result field against the predicted outcome, in order.
// ----------------------------------------------------------------------------
module fat_chain_manager_tb;
  import fcm_pkg::*;

  localparam longint CYCLE_LIMIT  = 25_000_000;
  localparam int     DRAIN_CYCLES = 2 * BLOCK_COUNT + 64;
  localparam int     MAX_HEADS    = 48;
  localparam int     QUIET_ITEMS  = 250;
  localparam logic [CMD_W-1:0] CMD_RESERVED_LO = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RESERVED_HI = 3'd7;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BLOCK_W-1:0]  blk;
    logic [OFFSET_W-1:0] left;
  } fat_outcome_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [CMD_W-1:0]    cmd;
  logic [BLOCK_W-1:0]  block;
  logic [OFFSET_W-1:0] byte_offset;
  logic                cfg_write;
  logic [BSZ_W-1:0]    cfg_data;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [BLOCK_W-1:0]  result_block;
  logic [OFFSET_W-1:0] offset_left;

  bit                 used_map [BLOCK_COUNT];
  logic [LINK_W-1:0]  link_table [BLOCK_COUNT];
  logic [BSZ_W-1:0]   bytes_per_block;
  int                 used_count;
  logic [BLOCK_W-1:0] heads_q [$];
  fat_outcome_t       pending_outcomes [$];
  int                 error_count;
  longint             cycle_count;
  bit                 idle_on;
  bit                 quiet;

  fat_chain_manager dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cmd          (cmd),
    .block        (block),
    .byte_offset  (byte_offset),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .done         (done),
    .status       (status),
    .result_block (result_block),
    .offset_left  (offset_left)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("fat_chain_manager test failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  always @(posedge clk) begin
    fat_outcome_t want;
    if (!rst && done !== 1'b0) begin
      if (done !== 1'b1) begin
        report_mismatch("done is unknown");
      end else if (pending_outcomes.size() == 0) begin
        report_mismatch("result with no item outstanding");
      end else begin
        want = pending_outcomes.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (result_block !== want.blk)
          report_mismatch($sformatf("result_block %0d, expected %0d", result_block, want.blk));
        if (offset_left !== want.left)
          report_mismatch($sformatf("offset_left %0d, expected %0d", offset_left, want.left));
      end
    end
  end

  function automatic bit has_successor(input logic [BLOCK_W-1:0] b);
    return link_table[b] != END_LINK && link_table[b] < BLOCK_COUNT;
  endfunction

  function automatic int lowest_free();
    for (int i = 0; i < BLOCK_COUNT; i++)
      if (!used_map[i]) return i;
    return -1;
  endfunction

  function automatic fat_outcome_t apply_fat_command(input logic [CMD_W-1:0] c,
                                                     input logic [BLOCK_W-1:0] b,
                                                     input logic [OFFSET_W-1:0] off);
    fat_outcome_t        r;
    int                  fb;
    int                  steps;
    logic [BLOCK_W-1:0]  cur;
    logic [BLOCK_W-1:0]  nb;
    logic [LINK_W-1:0]   old_link;
    logic [OFFSET_W-1:0] rem;
    logic [BSZ_W-1:0]    bsz;
    r = '0;
    if (c == CMD_CREATE) begin
      fb = lowest_free();
      if (fb < 0) begin
        r.status = ST_NO_FREE;
      end else begin
        used_map[fb] = 1'b1;
        link_table[fb] = END_LINK;
        used_count++;
        r.blk = fb[BLOCK_W-1:0];
      end
    end else if (c > CMD_SEEK) begin
      r = '0;
    end else if (!used_map[b]) begin
      r.status = ST_HEAD_UNUSED;
    end else begin
      case (c)
        CMD_EXTEND: begin
          old_link = link_table[b];
          fb = lowest_free();
          if (fb < 0) begin
            r.status = ST_NO_FREE;
          end else begin
            used_map[fb] = 1'b1;
            used_count++;
            link_table[fb] = old_link;
            link_table[b] = {1'b0, fb[BLOCK_W-1:0]};
            r.blk = fb[BLOCK_W-1:0];
          end
        end
        CMD_TRUNCATE: begin
          cur = b;
          steps = 0;
          while (steps < BLOCK_COUNT && has_successor(cur)) begin
            nb = link_table[cur][BLOCK_W-1:0];
            if (cur != b) link_table[cur] = END_LINK;
            used_map[nb] = 1'b0;
            used_count--;
            cur = nb;
            steps++;
          end
          link_table[cur] = END_LINK;
          link_table[b] = END_LINK;
          r.blk = b;
        end
        CMD_TAIL: begin
          cur = b;
          steps = 0;
          while (steps < BLOCK_COUNT && has_successor(cur)) begin
            cur = link_table[cur][BLOCK_W-1:0];
            steps++;
          end
          r.blk = cur;
        end
        default: begin
          bsz = (bytes_per_block == '0) ? BSZ_W'(1) : bytes_per_block;
          cur = b;
          rem = off;
          steps = 0;
          while (rem > bsz) begin
            if (!has_successor(cur) || steps >= BLOCK_COUNT) begin
              r.status = ST_CHAIN_END;
              break;
            end
            cur = link_table[cur][BLOCK_W-1:0];
            rem = rem - bsz;
            steps++;
          end
          r.blk = cur;
          r.left = rem;
        end
      endcase
    end
    return r;
  endfunction

  task automatic send_item(input logic [CMD_W-1:0] c, input logic [BLOCK_W-1:0] b,
                           input logic [OFFSET_W-1:0] off, output fat_outcome_t r);
    bit taken;
    taken = 1'b0;
    @(negedge clk);
    start = 1'b1;
    cmd = c;
    block = b;
    byte_offset = off;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    r = apply_fat_command(c, b, off);
    pending_outcomes.push_back(r);
    if (c == CMD_CREATE && r.status == ST_OK) heads_q.push_back(r.blk);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic pace();
    if (!quiet && idle_on && $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 15)) @(negedge clk);
  endtask

  task automatic wait_all_results();
    while (pending_outcomes.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_block_bytes(input logic [BSZ_W-1:0] value);
    wait_all_results();
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 1'b0;
    bytes_per_block = value;
  endtask

  function automatic logic [BLOCK_W-1:0] pick_block();
    int sel;
    int s;
    sel = $urandom_range(0, 9);
    if (sel < 6 && heads_q.size() > 0) return heads_q[$urandom_range(0, heads_q.size() - 1)];
    if (sel < 9) begin
      s = $urandom_range(0, BLOCK_COUNT - 1);
      for (int i = 0; i < BLOCK_COUNT; i++)
        if (used_map[(s + i) % BLOCK_COUNT]) return BLOCK_W'((s + i) % BLOCK_COUNT);
    end
    return BLOCK_W'($urandom_range(0, BLOCK_COUNT - 1));
  endfunction

  function automatic logic [OFFSET_W-1:0] pick_offset();
    int bsz;
    int k;
    bsz = (bytes_per_block == '0) ? 1 : int'(bytes_per_block);
    k = $urandom_range(0, 8);
    case ($urandom_range(0, 4))
      0: return OFFSET_W'($urandom_range(0, 8 * bsz));
      1: return OFFSET_W'(k * bsz);
      2: return OFFSET_W'(k * bsz + 1);
      default: return OFFSET_W'($urandom);
    endcase
  endfunction

  task automatic test_directed_commands();
    fat_outcome_t       r;
    logic [BLOCK_W-1:0] h;
    logic [BLOCK_W-1:0] a;
    send_item(CMD_CREATE, '0, '0, r);
    h = r.blk;
    send_item(CMD_EXTEND, '1, '0, r);
    send_item(CMD_TRUNCATE, '1, '0, r);
    send_item(CMD_TAIL, '1, '1, r);
    send_item(CMD_SEEK, '1, '1, r);
    for (int c = CMD_RESERVED_LO; c <= CMD_RESERVED_HI; c++)
      send_item(CMD_W'(c), (c == CMD_RESERVED_LO) ? h : '1, '1, r);
    send_item(CMD_EXTEND, h, '0, r);
    a = r.blk;
    send_item(CMD_EXTEND, a, '0, r);
    send_item(CMD_SEEK, h, OFFSET_W'(bytes_per_block), r);
    send_item(CMD_SEEK, h, OFFSET_W'(bytes_per_block) + 1'b1, r);
    send_item(CMD_SEEK, h, '0, r);
    send_item(CMD_SEEK, h, OFFSET_W'(2 * int'(bytes_per_block)), r);
    send_item(CMD_SEEK, h, '1, r);
    // Extending the head block splices the new block into the chain behind it.
    send_item(CMD_EXTEND, h, '0, r);
    send_item(CMD_TAIL, h, '0, r);
    send_item(CMD_TRUNCATE, a, '0, r);
    send_item(CMD_TAIL, h, '0, r);
    send_item(CMD_TRUNCATE, h, '0, r);
    send_item(CMD_TAIL, h, '0, r);
    send_item(CMD_SEEK, h, '1, r);
    send_item(CMD_CREATE, '1, '1, r);
  endtask

  task automatic test_block_size_extremes();
    fat_outcome_t       r;
    logic [BLOCK_W-1:0] h;
    logic [BLOCK_W-1:0] t;
    logic [BSZ_W-1:0]   sizes [7];
    int                 bsz;
    sizes = '{'0, BSZ_W'(1), BSZ_W'(2), '1, BSZ_W'(65536),
              BSZ_W'($urandom_range(3, 4096)), BLOCK_BYTES_RESET};
    send_item(CMD_CREATE, '0, '0, r);
    h = r.blk;
    t = h;
    repeat (4) begin
      send_item(CMD_EXTEND, t, '0, r);
      t = r.blk;
    end
    foreach (sizes[i]) begin
      write_block_bytes(sizes[i]);
      bsz = (sizes[i] == '0) ? 1 : int'(sizes[i]);
      send_item(CMD_SEEK, h, '0, r);
      send_item(CMD_SEEK, h, OFFSET_W'(bsz), r);
      send_item(CMD_SEEK, h, OFFSET_W'(bsz + 1), r);
      pace();
      send_item(CMD_SEEK, h, OFFSET_W'(3 * bsz), r);
      send_item(CMD_SEEK, h, OFFSET_W'(4 * bsz + 1), r);
      send_item(CMD_SEEK, h, '1, r);
      send_item(CMD_SEEK, h, OFFSET_W'($urandom), r);
    end
    send_item(CMD_TRUNCATE, h, '0, r);
  endtask

  task automatic test_full_disk();
    fat_outcome_t       r;
    logic [BLOCK_W-1:0] h;
    logic [BLOCK_W-1:0] t;
    send_item(CMD_CREATE, '0, '0, r);
    h = r.blk;
    t = h;
    while (used_count < BLOCK_COUNT) begin
      send_item(CMD_EXTEND, t, '0, r);
      t = r.blk;
    end
    send_item(CMD_CREATE, '0, '0, r);
    send_item(CMD_EXTEND, h, '0, r);
    send_item(CMD_TAIL, h, '0, r);
    write_block_bytes(BSZ_W'(1));
    send_item(CMD_SEEK, h, '1, r);
    send_item(CMD_SEEK, h, OFFSET_W'(BLOCK_COUNT / 2), r);
    write_block_bytes(BLOCK_BYTES_RESET);
    send_item(CMD_TRUNCATE, h, '0, r);
    send_item(CMD_TAIL, h, '0, r);
  endtask

  task automatic test_random_traffic(input int n_items);
    fat_outcome_t        r;
    int                  roll;
    logic [CMD_W-1:0]    c;
    logic [BLOCK_W-1:0]  b;
    logic [OFFSET_W-1:0] off;
    logic [BSZ_W-1:0]    sizes [7];
    sizes = '{BLOCK_BYTES_RESET, BSZ_W'(1), '0, '1, BSZ_W'(64),
              BSZ_W'($urandom_range(2, 4096)), BSZ_W'(65536)};
    for (int i = 0; i < n_items; i++) begin
      if (i > 0 && i % 300 == 0) write_block_bytes(sizes[(i / 300) % 7]);
      if (i % 50 == 0) idle_on = $urandom_range(0, 1);
      quiet = (i >= n_items - QUIET_ITEMS);
      roll = $urandom_range(0, 99);
      if (used_count > 160 && roll < 55) roll = 45;
      if (heads_q.size() == 0) roll = 0;
      if (roll < 6 && heads_q.size() < MAX_HEADS) c = CMD_CREATE;
      else if (roll < 40) c = CMD_EXTEND;
      else if (roll < 55) c = CMD_TRUNCATE;
      else if (roll < 70) c = CMD_TAIL;
      else if (roll < 94) c = CMD_SEEK;
      else c = CMD_W'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
      b = (c == CMD_CREATE) ? BLOCK_W'($urandom_range(0, BLOCK_COUNT - 1)) : pick_block();
      off = (c == CMD_SEEK) ? pick_offset() : OFFSET_W'($urandom);
      send_item(c, b, off, r);
      pace();
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = '0;
    block = '0;
    byte_offset = '0;
    cfg_write = 1'b0;
    cfg_data = '0;
    error_count = 0;
    cycle_count = 0;
    idle_on = 1'b1;
    quiet = 1'b0;
    used_count = 0;
    bytes_per_block = BLOCK_BYTES_RESET;
    for (int i = 0; i < BLOCK_COUNT; i++) begin
      used_map[i] = 1'b0;
      link_table[i] = END_LINK;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_commands();
    test_block_size_extremes();
    test_full_disk();
    test_random_traffic(745);

    wait_all_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("fat_chain_manager test passed");
    end else begin
      $display("fat_chain_manager test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/fcm_pkg.sv
hdl/fcm_tables.sv
hdl/fat_chain_manager.sv
dv/fat_chain_manager_tb.sv
